### rtl/wcht_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and codes of the word count hash table.
// No dependencies; the top level, hash unit, controller and testbench import this package.
package wcht_pkg;

  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int KEY_CHARS_DEF   = 8;
  localparam int MAX_DOCS_DEF    = 8;

  localparam int NUM_WEIGHTS = 8;
  localparam int WEIGHT_W    = 14;
  localparam int CFG_IDX_W   = 3;
  localparam int KEY_BITS    = 64;
  localparam int DOC_W       = 3;
  localparam int SEL_W       = 10;
  localparam int COUNT_W     = 16;

  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 96;

  typedef enum logic [1:0] {
    STATUS_COUNTED  = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_FULL     = 2'd2,
    STATUS_READ     = 2'd3
  } wcht_status_e;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] wcht_weights_t;

  typedef struct packed {
    logic                action;
    logic [KEY_BITS-1:0] word_key;
    logic [DOC_W-1:0]    doc_number;
    logic [SEL_W-1:0]    slot_select;
  } wcht_req_t;

  typedef struct packed {
    wcht_status_e        status;
    logic [SEL_W-1:0]    slot_index;
    logic                slot_valid;
    logic [KEY_BITS-1:0] stored_key;
    logic [COUNT_W-1:0]  doc_count;
  } wcht_result_t;

endpackage

### rtl/word_count_hash_table.sv
`timescale 1ns / 1ps
// Top level of the word count hash table: stream ports, weight registers and
// the memories. Depends on wcht_pkg, wcht_ram, wcht_hash and wcht_ctrl.
//
// Open-addressing hash table with linear probing that counts key occurrences
// per document and reads back single slots. After reset the block runs a
// clearing pass over the counter memory, with s_axis_tready low; weight
// writes are taken during it. In a count transaction the weighted hash sums
// one character per cycle through a single multiplier, the modulo reduction
// multiplies by a reciprocal, multiplies back by the table size and corrects
// once, and the probe reads one slot per cycle from the key and counter
// memories. A read transaction reduces slot_select the same way and reads
// that one slot. One transaction is processed at a time; a result waiting
// in the output register does not block acceptance.
module word_count_hash_table #(
  parameter int TABLE_SLOTS = wcht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = wcht_pkg::KEY_CHARS_DEF,
  parameter int MAX_DOCS    = wcht_pkg::MAX_DOCS_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [wcht_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [wcht_pkg::WEIGHT_W-1:0]      cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // Fields from bit 0: word_key (64), doc_number (3), slot_select (10), zero pad.
  input  logic [wcht_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // Fields from bit 0: action (1).
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // Fields from bit 0: slot_index (10), slot_valid (1), stored_key (64),
  // doc_count (16), zero pad.
  output logic [wcht_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Fields from bit 0: status (2).
  output logic [1:0]                         m_axis_tuser
);
  import wcht_pkg::*;

  localparam int KEY_W  = 8 * KEY_CHARS;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int ROW_W  = 1 + COUNT_W * MAX_DOCS;

  wcht_weights_t     weight_q, weight_d;
  wcht_req_t         req;
  wcht_result_t      result;

  logic              hash_start, hash_use_key, hash_done;
  logic [KEY_W-1:0]  hash_key;
  logic [SEL_W-1:0]  hash_value;
  logic [SLOT_W-1:0] hash_slot;

  logic              mem_re;
  logic [SLOT_W-1:0] mem_raddr;
  logic              key_we;
  logic [SLOT_W-1:0] key_waddr;
  logic [KEY_W-1:0]  key_wdata, key_rdata;
  logic              cnt_we;
  logic [SLOT_W-1:0] cnt_waddr;
  logic [ROW_W-1:0]  cnt_wdata, cnt_rdata;

  always_comb begin
    weight_d = weight_q;
    if (cfg_we_i) begin
      weight_d[cfg_index_i] = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_WEIGHTS; i++) begin
        weight_q[i] <= WEIGHT_W'(1);
      end
    end else begin
      weight_q <= weight_d;
    end
  end

  assign req.action      = s_axis_tuser[0];
  assign req.word_key    = s_axis_tdata[KEY_BITS-1:0];
  assign req.doc_number  = s_axis_tdata[KEY_BITS +: DOC_W];
  assign req.slot_select = s_axis_tdata[KEY_BITS + DOC_W +: SEL_W];

  wcht_hash #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_CHARS   (KEY_CHARS)
  ) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (hash_start),
    .use_key_i (hash_use_key),
    .key_i     (hash_key),
    .value_i   (hash_value),
    .weights_i (weight_q),
    .done_o    (hash_done),
    .slot_o    (hash_slot)
  );

  wcht_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_key_ram (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .waddr_i (key_waddr),
    .wdata_i (key_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (key_rdata)
  );

  wcht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (TABLE_SLOTS)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (cnt_rdata)
  );

  wcht_ctrl #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_CHARS   (KEY_CHARS),
    .MAX_DOCS    (MAX_DOCS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_axis_tvalid),
    .in_ready_o     (s_axis_tready),
    .req_i          (req),
    .hash_start_o   (hash_start),
    .hash_use_key_o (hash_use_key),
    .hash_key_o     (hash_key),
    .hash_value_o   (hash_value),
    .hash_done_i    (hash_done),
    .hash_slot_i    (hash_slot),
    .mem_re_o       (mem_re),
    .mem_raddr_o    (mem_raddr),
    .key_we_o       (key_we),
    .key_waddr_o    (key_waddr),
    .key_wdata_o    (key_wdata),
    .key_rdata_i    (key_rdata),
    .cnt_we_o       (cnt_we),
    .cnt_waddr_o    (cnt_waddr),
    .cnt_wdata_o    (cnt_wdata),
    .cnt_rdata_i    (cnt_rdata),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .result_o       (result)
  );

  assign m_axis_tuser = result.status;
  assign m_axis_tdata = OUT_TDATA_W'({result.doc_count, result.stored_key,
                                      result.slot_valid, result.slot_index});

endmodule

### rtl/wcht_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module wcht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/wcht_hash.sv
`timescale 1ns / 1ps
// Home slot unit: weighted character sum (one character per cycle) or value_i,
// then a reciprocal-multiply reduction modulo the table size. Depends on wcht_pkg.
module wcht_hash #(
  parameter int TABLE_SLOTS = wcht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = wcht_pkg::KEY_CHARS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic                             use_key_i,
  input  logic [8*KEY_CHARS-1:0]           key_i,
  input  logic [wcht_pkg::SEL_W-1:0]       value_i,
  input  wcht_pkg::wcht_weights_t          weights_i,
  output logic                             done_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]   slot_o
);
  import wcht_pkg::*;

  localparam int KEY_W  = 8 * KEY_CHARS;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int HASH_W = $clog2(KEY_CHARS * 255 * 16383 + 1);
  localparam int PROD_W = 2 * HASH_W;
  localparam int TAB_W  = SLOT_W + 1;
  localparam int P2_W   = HASH_W + TAB_W;
  localparam int MAC_W  = 8 + WEIGHT_W;
  localparam int RECIP  = (2 ** HASH_W) / TABLE_SLOTS;

  localparam logic [2:0] HS_IDLE = 3'd0;
  localparam logic [2:0] HS_MAC  = 3'd1;
  localparam logic [2:0] HS_MUL1 = 3'd2;
  localparam logic [2:0] HS_MUL2 = 3'd3;
  localparam logic [2:0] HS_CORR = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [2:0]        ci_q, ci_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [HASH_W-1:0] acc_q, acc_d;
  logic [PROD_W-1:0] p1_q, p1_d;
  logic [P2_W-1:0]   p2_q, p2_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              done_q, done_d;
  logic [MAC_W-1:0]  mac_prod;
  logic [TAB_W-1:0]  rem;

  always_comb begin
    state_d  = state_q;
    ci_d     = ci_q;
    key_d    = key_q;
    acc_d    = acc_q;
    p1_d     = p1_q;
    p2_d     = p2_q;
    slot_d   = slot_q;
    done_d   = 1'b0;
    mac_prod = MAC_W'(key_q[7:0]) * MAC_W'(weights_i[ci_q]);
    rem      = TAB_W'(acc_q) - TAB_W'(p2_q);
    if (rem >= TAB_W'(TABLE_SLOTS)) begin
      rem = rem - TAB_W'(TABLE_SLOTS);
    end
    unique case (state_q)
      HS_IDLE: begin
        if (start_i) begin
          ci_d  = '0;
          key_d = key_i;
          if (use_key_i) begin
            acc_d   = '0;
            state_d = HS_MAC;
          end else begin
            acc_d   = HASH_W'(value_i);
            state_d = HS_MUL1;
          end
        end
      end
      HS_MAC: begin
        acc_d = acc_q + HASH_W'(mac_prod);
        key_d = key_q >> 8;
        ci_d  = ci_q + 3'd1;
        if (ci_q == 3'(KEY_CHARS - 1)) begin
          state_d = HS_MUL1;
        end
      end
      HS_MUL1: begin
        p1_d    = PROD_W'(acc_q) * PROD_W'(RECIP);
        state_d = HS_MUL2;
      end
      HS_MUL2: begin
        p2_d    = P2_W'(p1_q[PROD_W-1:HASH_W]) * P2_W'(TABLE_SLOTS);
        state_d = HS_CORR;
      end
      HS_CORR: begin
        slot_d  = rem[SLOT_W-1:0];
        done_d  = 1'b1;
        state_d = HS_IDLE;
      end
      default: begin
        state_d = HS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= HS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ci_q   <= ci_d;
    key_q  <= key_d;
    acc_q  <= acc_d;
    p1_q   <= p1_d;
    p2_q   <= p2_d;
    slot_q <= slot_d;
  end

  assign done_o = done_q;
  assign slot_o = slot_q;

endmodule

### rtl/wcht_ctrl.sv
`timescale 1ns / 1ps
// Table controller: clearing pass, linear probe over the two table memories,
// read-modify-write of the counter rows and the result register. Depends on wcht_pkg.
module wcht_ctrl #(
  parameter int TABLE_SLOTS = wcht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_CHARS   = wcht_pkg::KEY_CHARS_DEF,
  parameter int MAX_DOCS    = wcht_pkg::MAX_DOCS_DEF
) (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      in_valid_i,
  output logic                                      in_ready_o,
  input  wcht_pkg::wcht_req_t                       req_i,
  output logic                                      hash_start_o,
  output logic                                      hash_use_key_o,
  output logic [8*KEY_CHARS-1:0]                    hash_key_o,
  output logic [wcht_pkg::SEL_W-1:0]                hash_value_o,
  input  logic                                      hash_done_i,
  input  logic [$clog2(TABLE_SLOTS)-1:0]            hash_slot_i,
  output logic                                      mem_re_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]            mem_raddr_o,
  output logic                                      key_we_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]            key_waddr_o,
  output logic [8*KEY_CHARS-1:0]                    key_wdata_o,
  input  logic [8*KEY_CHARS-1:0]                    key_rdata_i,
  output logic                                      cnt_we_o,
  output logic [$clog2(TABLE_SLOTS)-1:0]            cnt_waddr_o,
  output logic [1+wcht_pkg::COUNT_W*MAX_DOCS-1:0]   cnt_wdata_o,
  input  logic [1+wcht_pkg::COUNT_W*MAX_DOCS-1:0]   cnt_rdata_i,
  output logic                                      out_valid_o,
  input  logic                                      out_ready_i,
  output wcht_pkg::wcht_result_t                    result_o
);
  import wcht_pkg::*;

  localparam int KEY_W  = 8 * KEY_CHARS;
  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int ROW_W  = 1 + COUNT_W * MAX_DOCS;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HASH  = 3'd2;
  localparam logic [2:0] ST_PROBE = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [SLOT_W-1:0] clr_q, clr_d;
  logic              action_q, action_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [DOC_W-1:0]  doc_q, doc_d;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [SLOT_W:0]   probe_q, probe_d;
  wcht_result_t      res_q, res_d;
  wcht_result_t      out_q, out_d;
  logic              out_valid_q, out_valid_d;

  logic               accept;
  logic [DOC_W-1:0]   doc_red;
  logic [COUNT_W-1:0] cnt_cur, cnt_new;
  logic [ROW_W-1:0]   row_upd, row_ins;
  logic               row_used, key_hit;
  logic [SLOT_W-1:0]  slot_next;

  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    doc_red = req_i.doc_number;
    for (int k = 0; k < 7; k++) begin
      if (int'(doc_red) >= MAX_DOCS) begin
        doc_red = doc_red - DOC_W'(MAX_DOCS);
      end
    end
  end

  always_comb begin
    cnt_cur = '0;
    for (int l = 0; l < MAX_DOCS; l++) begin
      if (int'(doc_q) == l) begin
        cnt_cur = cnt_rdata_i[1 + COUNT_W*l +: COUNT_W];
      end
    end
    cnt_new = (cnt_cur == '1) ? cnt_cur : cnt_cur + COUNT_W'(1);
    row_upd = cnt_rdata_i;
    row_ins = ROW_W'(1);
    for (int l = 0; l < MAX_DOCS; l++) begin
      if (int'(doc_q) == l) begin
        row_upd[1 + COUNT_W*l +: COUNT_W] = cnt_new;
        row_ins[1 + COUNT_W*l +: COUNT_W] = COUNT_W'(1);
      end
    end
  end

  assign row_used  = cnt_rdata_i[0];
  assign key_hit   = (key_rdata_i == key_q);
  assign slot_next = (slot_q == SLOT_W'(TABLE_SLOTS - 1)) ? '0 : slot_q + SLOT_W'(1);

  always_comb begin
    state_d        = state_q;
    clr_d          = clr_q;
    action_d       = action_q;
    key_d          = key_q;
    doc_d          = doc_q;
    slot_d         = slot_q;
    probe_d        = probe_q;
    res_d          = res_q;
    out_d          = out_q;
    out_valid_d    = out_valid_q;
    in_ready_o     = (state_q == ST_IDLE);
    hash_start_o   = 1'b0;
    hash_use_key_o = !req_i.action;
    hash_key_o     = req_i.word_key[KEY_W-1:0];
    hash_value_o   = req_i.slot_select;
    mem_re_o       = 1'b0;
    mem_raddr_o    = slot_q;
    key_we_o       = 1'b0;
    key_waddr_o    = slot_q;
    key_wdata_o    = key_q;
    cnt_we_o       = 1'b0;
    cnt_waddr_o    = slot_q;
    cnt_wdata_o    = row_upd;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        cnt_we_o    = 1'b1;
        cnt_waddr_o = clr_q;
        cnt_wdata_o = '0;
        clr_d       = clr_q + SLOT_W'(1);
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          hash_start_o = 1'b1;
          action_d     = req_i.action;
          key_d        = req_i.word_key[KEY_W-1:0];
          doc_d        = doc_red;
          state_d      = ST_HASH;
        end
      end
      ST_HASH: begin
        if (hash_done_i) begin
          mem_re_o    = 1'b1;
          mem_raddr_o = hash_slot_i;
          slot_d      = hash_slot_i;
          probe_d     = '0;
          state_d     = ST_PROBE;
        end
      end
      ST_PROBE: begin
        res_d.slot_index = SEL_W'(slot_q);
        res_d.slot_valid = 1'b1;
        res_d.stored_key = KEY_BITS'(key_q);
        priority if (action_q) begin
          res_d.status     = STATUS_READ;
          res_d.slot_valid = row_used;
          res_d.stored_key = row_used ? KEY_BITS'(key_rdata_i) : '0;
          res_d.doc_count  = row_used ? cnt_cur : '0;
          state_d          = ST_EMIT;
        end else if (!row_used) begin
          key_we_o        = 1'b1;
          cnt_we_o        = 1'b1;
          cnt_wdata_o     = row_ins;
          res_d.status    = STATUS_INSERTED;
          res_d.doc_count = COUNT_W'(1);
          state_d         = ST_EMIT;
        end else if (key_hit) begin
          cnt_we_o        = 1'b1;
          res_d.status    = STATUS_COUNTED;
          res_d.doc_count = cnt_new;
          state_d         = ST_EMIT;
        end else if (probe_q == (SLOT_W+1)'(TABLE_SLOTS - 1)) begin
          res_d.status     = STATUS_FULL;
          res_d.slot_index = '0;
          res_d.slot_valid = 1'b0;
          res_d.stored_key = '0;
          res_d.doc_count  = '0;
          state_d          = ST_EMIT;
        end else begin
          mem_re_o    = 1'b1;
          mem_raddr_o = slot_next;
          slot_d      = slot_next;
          probe_d     = probe_q + (SLOT_W+1)'(1);
        end
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    key_q    <= key_d;
    doc_q    <= doc_d;
    slot_q   <= slot_d;
    probe_q  <= probe_d;
    res_q    <= res_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = out_q;

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench of word_count_hash_table: stream stimulus, a tally
// predictor and checker, and random idling. Depends on wcht_pkg and the RTL.
module tb_top;
  import wcht_pkg::*;

  localparam int SLOTS         = TABLE_SLOTS_DEF;
  localparam int DOCS          = MAX_DOCS_DEF;
  localparam int STALL_LIMIT   = 20000;
  localparam int HOLD_CYCLES   = 400;
  localparam int REPEAT_RUNS   = 80;
  localparam int POOL_DEPTH    = 400;

  class tally_checker;
    bit [WEIGHT_W-1:0] weights [NUM_WEIGHTS];
    bit [KEY_BITS-1:0] slot_keys [SLOTS];
    bit                slot_used [SLOTS];
    bit [COUNT_W-1:0]  doc_tallies [SLOTS*DOCS];
    int                used_total;
    int                mismatch_count;
    int                status_seen [4];
    wcht_result_t      expected_results [$];

    function new();
      foreach (weights[i]) weights[i] = WEIGHT_W'(1);
    endfunction

    function void set_weights(wcht_weights_t w);
      for (int i = 0; i < NUM_WEIGHTS; i++) weights[i] = w[i];
    endfunction

    function wcht_result_t predict_tally(wcht_req_t req);
      wcht_result_t res;
      bit [63:0] sum;
      int home;
      int slot;
      int n;
      res = '0;
      if (req.action) begin
        slot = int'(req.slot_select);
        res.status = STATUS_READ;
        res.slot_index = SEL_W'(slot);
        if (slot_used[slot]) begin
          res.slot_valid = 1'b1;
          res.stored_key = slot_keys[slot];
          res.doc_count = doc_tallies[slot*DOCS + int'(req.doc_number)];
        end
        return res;
      end
      sum = 0;
      for (int i = 0; i < NUM_WEIGHTS; i++)
        sum = sum + 64'(req.word_key[8*i +: 8]) * 64'(weights[i]);
      home = int'(sum % 64'(SLOTS));
      res.status = STATUS_FULL;
      for (n = 0; n < SLOTS; n++) begin
        slot = (home + n) % SLOTS;
        if (!slot_used[slot]) begin
          slot_used[slot] = 1'b1;
          slot_keys[slot] = req.word_key;
          doc_tallies[slot*DOCS + int'(req.doc_number)] = COUNT_W'(1);
          used_total++;
          res.status = STATUS_INSERTED;
          res.slot_index = SEL_W'(slot);
          res.slot_valid = 1'b1;
          res.stored_key = req.word_key;
          res.doc_count = COUNT_W'(1);
          return res;
        end
        if (slot_keys[slot] == req.word_key) begin
          if (doc_tallies[slot*DOCS + int'(req.doc_number)] != 16'hFFFF)
            doc_tallies[slot*DOCS + int'(req.doc_number)]++;
          res.status = STATUS_COUNTED;
          res.slot_index = SEL_W'(slot);
          res.slot_valid = 1'b1;
          res.stored_key = req.word_key;
          res.doc_count = doc_tallies[slot*DOCS + int'(req.doc_number)];
          return res;
        end
      end
      return res;
    endfunction

    function void note_request(wcht_req_t req);
      expected_results.push_back(predict_tally(req));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    function void compare_field(string name, logic [63:0] expected, logic [63:0] actual);
      if (actual !== expected) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, expected, actual);
        mismatch_count++;
      end
    endfunction

    function void check_result(logic [1:0] status, logic [SEL_W-1:0] index, logic valid,
                               logic [KEY_BITS-1:0] key, logic [COUNT_W-1:0] count);
      wcht_result_t exp;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status %0h slot %0h",
                 $time, status, index);
        mismatch_count++;
        return;
      end
      exp = expected_results.pop_front();
      status_seen[exp.status]++;
      compare_field("status", 64'(exp.status), 64'(status));
      compare_field("slot_index", 64'(exp.slot_index), 64'(index));
      compare_field("slot_valid", 64'(exp.slot_valid), 64'(valid));
      compare_field("stored_key", exp.stored_key, key);
      compare_field("doc_count", 64'(exp.doc_count), 64'(count));
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [WEIGHT_W-1:0]    cfg_data_i;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [0:0]             s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic [1:0]             m_axis_tuser;

  tally_checker      sb;
  bit [KEY_BITS-1:0] key_pool [$];
  bit                tx_idle_on;
  bit                rx_idle_on;
  int                rx_hold;
  int                idle_cycles;

  always #5 clk_i = ~clk_i;

  word_count_hash_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(m_axis_tuser, m_axis_tdata[9:0], m_axis_tdata[10], m_axis_tdata[74:11],
                      m_axis_tdata[90:75]);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("Timeout after %0d cycles without a transaction", idle_cycles);
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int stall;
    m_axis_tready = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (rx_hold > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_hold) @(negedge clk_i);
        rx_hold = 0;
      end
      stall = rx_idle_on ? $urandom_range(0, 6) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  task automatic send_item(wcht_req_t req);
    int gap;
    gap = tx_idle_on ? $urandom_range(0, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - 77){1'b0}}, req.slot_select, req.doc_number, req.word_key};
    s_axis_tuser <= req.action;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_request(req);
  endtask

  task automatic count_key(bit [KEY_BITS-1:0] key, int doc);
    wcht_req_t req;
    req.action = 1'b0;
    req.word_key = key;
    req.doc_number = DOC_W'(doc);
    req.slot_select = SEL_W'($urandom_range(0, SLOTS - 1));
    send_item(req);
  endtask

  task automatic read_slot(int slot, int doc);
    wcht_req_t req;
    req.action = 1'b1;
    req.word_key = {$urandom, $urandom};
    req.doc_number = DOC_W'(doc);
    req.slot_select = SEL_W'(slot);
    send_item(req);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
  endtask

  task automatic load_weights(wcht_weights_t w);
    for (int i = 0; i < NUM_WEIGHTS; i++) begin
      @(negedge clk_i);
      cfg_we_i <= 1'b1;
      cfg_index_i <= CFG_IDX_W'(i);
      cfg_data_i <= w[i];
    end
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_weights(w);
  endtask

  function automatic int pick_used_slot();
    int start;
    start = $urandom_range(0, SLOTS - 1);
    for (int n = 0; n < SLOTS; n++) begin
      if (sb.slot_used[(start + n) % SLOTS]) return (start + n) % SLOTS;
    end
    return 0;
  endfunction

  function automatic bit [KEY_BITS-1:0] text_word();
    bit [KEY_BITS-1:0] word;
    int len;
    word = {8{8'h20}};
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) word[8*i +: 8] = 8'h61 + 8'($urandom_range(0, 25));
    return word;
  endfunction

  task automatic random_transaction();
    wcht_req_t req;
    int pick;
    pick = $urandom_range(0, 99);
    req.action = 1'b0;
    req.word_key = {$urandom, $urandom};
    req.doc_number = DOC_W'($urandom_range(0, DOCS - 1));
    req.slot_select = SEL_W'($urandom_range(0, SLOTS - 1));
    if (pick < 20 && sb.used_total > 0) begin
      req.action = 1'b1;
      req.slot_select = SEL_W'(pick_used_slot());
    end else if (pick < 60 && key_pool.size() > 0) begin
      req.word_key = key_pool[$urandom_range(0, key_pool.size() - 1)];
    end else begin
      if (pick < 80) req.word_key = text_word();
      key_pool.push_back(req.word_key);
      if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
    end
    send_item(req);
  endtask

  task automatic random_phase(int items, int hold_at);
    for (int k = 0; k < items; k++) begin
      if (k % 100 == 0) begin
        tx_idle_on = $urandom_range(0, 3) != 0;
        rx_idle_on = $urandom_range(0, 3) != 0;
      end
      if (k == hold_at) rx_hold = HOLD_CYCLES;
      random_transaction();
    end
  endtask

  // With weight 1 on character 0 and 256 on character 1, a key whose low ten
  // bits spell a slot number hashes straight to that slot.
  task automatic fill_table();
    bit [KEY_BITS-1:0] key;
    bit [SEL_W-1:0]    slot;
    bit [5:0]          upper;
    for (int s = 0; s < SLOTS; s++) begin
      if (!sb.slot_used[s]) begin
        slot = SEL_W'(s);
        upper = 6'($urandom_range(0, 63));
        key = {$urandom, $urandom};
        key[15:0] = {upper, slot[9:8], slot[7:0]};
        count_key(key, $urandom_range(0, DOCS - 1));
        if ($urandom_range(0, 5) == 0) read_slot(pick_used_slot(), $urandom_range(0, DOCS - 1));
      end
    end
  endtask

  initial begin
    wcht_weights_t w;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    rx_hold = 0;
    idle_cycles = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Reset weights: zero key, all-ones key, anagrams that share a home slot,
    // and two keys homed on the last slot so that the probe wraps to slot 0.
    count_key(64'h0, 0);
    count_key({KEY_BITS{1'b1}}, 7);
    count_key(64'h2020206F6C6C6568, 3);
    count_key(64'h2020206F6C6C6568, 3);
    count_key(64'h2020206F6C6C6568, 4);
    count_key(64'h20202068656C6C6F, 1);
    count_key(64'h0, 7);
    count_key(64'h00000003FFFFFFFF, 2);
    count_key(64'h000000FFFFFFFF03, 6);
    read_slot(0, 7);
    read_slot(0, 0);
    read_slot(1016, 7);
    read_slot(628, 3);
    read_slot(628, 4);
    read_slot(629, 1);
    read_slot(1023, 2);
    read_slot(1, 6);
    read_slot(1, 5);

    // Repeated counts of one key back to back, with no idling.
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    for (int k = 0; k < REPEAT_RUNS; k++) count_key(64'h0, 2);
    read_slot(0, 2);
    drain_results();

    for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = WEIGHT_W'($urandom_range(1, 10000));
    load_weights(w);
    random_phase(700, 250);
    drain_results();

    for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = WEIGHT_W'(10000);
    load_weights(w);
    random_phase(150, -1);
    drain_results();

    for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = '1;
    load_weights(w);
    random_phase(150, -1);
    drain_results();

    for (int i = 0; i < NUM_WEIGHTS; i++) w[i] = (i % 2 == 0) ? '0 : '1;
    load_weights(w);
    random_phase(150, -1);
    drain_results();

    // All weights zero send every key to slot 0, so probes get long.
    w = '0;
    load_weights(w);
    random_phase(40, -1);
    drain_results();

    w = '0;
    w[0] = WEIGHT_W'(1);
    w[1] = WEIGHT_W'(256);
    load_weights(w);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    fill_table();
    random_phase(30, -1);
    drain_results();
    repeat (50) @(posedge clk_i);

    $display("Checked %0d counted, %0d inserted, %0d table-full and %0d read results,",
             sb.status_seen[STATUS_COUNTED], sb.status_seen[STATUS_INSERTED],
             sb.status_seen[STATUS_FULL], sb.status_seen[STATUS_READ]);
    $display("over seven weight settings, a heavily counted key and a completely filled table.");
    if (sb.mismatch_count == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule

### word_count_hash_table.f
rtl/wcht_pkg.sv
rtl/wcht_ram.sv
rtl/wcht_hash.sv
rtl/wcht_ctrl.sv
rtl/word_count_hash_table.sv
test/tb_top.sv
